// ===== rtl/core/teq_pkg.sv =====
// Shared types, widths, register codes and arithmetic helpers for the
// stereo tilt equalizer core. No dependencies.
package teq_pkg;

   localparam int SMP_W = 16;
   localparam int EFF_W = SMP_W + 1;
   localparam int OPA_W = SMP_W + 2;
   localparam int WGT_W = 9;
   localparam int ACC_W = OPA_W + WGT_W + 1;
   localparam int QUO_W = ACC_W - 8;
   localparam int IDX_W = 3;

   localparam logic [WGT_W-1:0] WEIGHT_ONE = 9'd256;
   localparam logic signed [QUO_W-1:0] SAT_HI = QUO_W'(32767);
   localparam logic signed [QUO_W-1:0] SAT_LO = -QUO_W'(32768);

   localparam logic [IDX_W-1:0] REG_LEFT_CENTRE  = 3'd0;
   localparam logic [IDX_W-1:0] REG_LEFT_TONE    = 3'd1;
   localparam logic [IDX_W-1:0] REG_RIGHT_CENTRE = 3'd2;
   localparam logic [IDX_W-1:0] REG_RIGHT_TONE   = 3'd3;
   localparam logic [IDX_W-1:0] REG_WET_MIX      = 3'd4;
   localparam logic [IDX_W-1:0] REG_STEREO_MODE  = 3'd5;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_LOW_A,
      STEP_LOW_B,
      STEP_LOW_DIV,
      STEP_EFF_A,
      STEP_EFF_B,
      STEP_EFF_DIV,
      STEP_OUT_A,
      STEP_OUT_B,
      STEP_OUT_DIV,
      STEP_HOLD
   } teq_step_type;

   typedef struct packed {
      logic         load;
      teq_step_type step;
   } teq_ctl_type;

   // values above one are used as one
   function automatic logic [WGT_W-1:0] clamp_weight(input logic [WGT_W-1:0] v);
      return v[WGT_W-1] ? WEIGHT_ONE : v;
   endfunction

   // divide by 256, truncating toward zero
   function automatic logic signed [QUO_W-1:0] div256(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] adj;
      adj = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
      return adj[ACC_W-1:8];
   endfunction

endpackage

// ===== rtl/core/stereo_tilt_eq_mixer_core.sv =====
// Top level of the stereo tilt equalizer: configuration registers, two
// lanes, sequencer and output register. Depends on teq_pkg, teq_lane, teq_ctrl.
//
// Usage:
//   req_* carries one stereo frame per request; rsp_* returns one processed
//   frame per request, in order. csr_* writes a configuration register
//   (index 0..5: left centre, left tone, right centre, right tone, wet mix,
//   stereo mode); csr_ready is always high and other indexes are ignored.
//   Weight values above 256 are stored as 256.
// Timing:
//   Both lanes run side by side through nine steps on their own
//   multiply-accumulate unit (two products and a divide for each of lowpass,
//   tilt blend and output mix), then a hold step merges the lanes into the
//   output register. A request is taken only in the idle step, so a new frame
//   is accepted only after the previous one has been merged into the output
//   register and the sequencer has returned to idle.
// Reset:
//   Clears filter history, sets registers to their defaults (centre and tone
//   128, wet 0, mono) and empties the output register.
// Backpressure:
//   A new request is accepted while a result waits in the output register;
//   the lanes then hold the finished frame until rsp_tready frees the register.
module stereo_tilt_eq_mixer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*teq_pkg::SMP_W-1:0]      req_tdata,  // right_sample (upper half), left_sample (lower half)
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2*teq_pkg::SMP_W-1:0]      rsp_tdata,  // right_result (upper half), left_result (lower half)
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [teq_pkg::IDX_W-1:0]        csr_index,
   input  logic [teq_pkg::WGT_W-1:0]        csr_data
);
   import teq_pkg::*;

   logic [WGT_W-1:0] left_centre_ff, left_centre_in;
   logic [WGT_W-1:0] left_tone_ff, left_tone_in;
   logic [WGT_W-1:0] right_centre_ff, right_centre_in;
   logic [WGT_W-1:0] right_tone_ff, right_tone_in;
   logic [WGT_W-1:0] wet_mix_ff, wet_mix_in;
   logic             stereo_mode_ff, stereo_mode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2*SMP_W-1:0] rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             out_load;
   teq_ctl_type      ctl;
   logic [WGT_W-1:0] lane1_centre;
   logic [WGT_W-1:0] lane1_tone;
   logic [WGT_W-1:0] wclamp;
   logic signed [SMP_W-1:0] left_result;
   logic signed [SMP_W-1:0] right_result;

   assign csr_ready = 1'b1;
   assign wclamp    = clamp_weight(csr_data);

   always_comb begin
      left_centre_in  = left_centre_ff;
      left_tone_in    = left_tone_ff;
      right_centre_in = right_centre_ff;
      right_tone_in   = right_tone_ff;
      wet_mix_in      = wet_mix_ff;
      stereo_mode_in  = stereo_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LEFT_CENTRE:  left_centre_in  = wclamp;
            REG_LEFT_TONE:    left_tone_in    = wclamp;
            REG_RIGHT_CENTRE: right_centre_in = wclamp;
            REG_RIGHT_TONE:   right_tone_in   = wclamp;
            REG_WET_MIX:      wet_mix_in      = wclamp;
            REG_STEREO_MODE:  stereo_mode_in  = csr_data[0];
            default:          stereo_mode_in  = stereo_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_centre_ff  <= 9'd128;
         left_tone_ff    <= 9'd128;
         right_centre_ff <= 9'd128;
         right_tone_ff   <= 9'd128;
         wet_mix_ff      <= '0;
         stereo_mode_ff  <= 1'b0;
      end else begin
         left_centre_ff  <= left_centre_in;
         left_tone_ff    <= left_tone_in;
         right_centre_ff <= right_centre_in;
         right_tone_ff   <= right_tone_in;
         wet_mix_ff      <= wet_mix_in;
         stereo_mode_ff  <= stereo_mode_in;
      end
   end

   // mono: second lane follows first lane settings
   assign lane1_centre = stereo_mode_ff ? right_centre_ff : left_centre_ff;
   assign lane1_tone   = stereo_mode_ff ? right_tone_ff : left_tone_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   teq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .req_ready (req_tready),
      .out_load  (out_load),
      .ctl       (ctl)
   );

   teq_lane u_lane0 (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample ($signed(req_tdata[SMP_W-1:0])),
      .centre (left_centre_ff),
      .tone   (left_tone_ff),
      .wet    (wet_mix_ff),
      .result (left_result)
   );

   teq_lane u_lane1 (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample ($signed(req_tdata[2*SMP_W-1:SMP_W])),
      .centre (lane1_centre),
      .tone   (lane1_tone),
      .wet    (wet_mix_ff),
      .result (right_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {right_result, left_result};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_weights_clamped: assert property (@(posedge clock) disable iff (reset)
      (left_centre_ff <= WEIGHT_ONE) && (left_tone_ff <= WEIGHT_ONE) &&
      (right_centre_ff <= WEIGHT_ONE) && (right_tone_ff <= WEIGHT_ONE) &&
      (wet_mix_ff <= WEIGHT_ONE))
      else $error("weight register above one");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(out_load))
      else $error("response raised without a merged frame");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while lanes busy");

endmodule

// ===== rtl/core/teq_lane.sv =====
// One equalizer lane: lowpass, tilt blend and dry/wet mix on a shared
// multiply-accumulate unit. Depends on teq_pkg.
module teq_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  teq_pkg::teq_ctl_type             ctl,
   input  logic signed [teq_pkg::SMP_W-1:0] sample,
   input  logic [teq_pkg::WGT_W-1:0]        centre,
   input  logic [teq_pkg::WGT_W-1:0]        tone,
   input  logic [teq_pkg::WGT_W-1:0]        wet,
   output logic signed [teq_pkg::SMP_W-1:0] result
);
   import teq_pkg::*;

   logic signed [SMP_W-1:0] sample_ff, sample_in;
   logic signed [SMP_W-1:0] pin_ff, pin_in;
   logic signed [SMP_W-1:0] plow_ff, plow_in;
   logic signed [SMP_W-1:0] low_ff, low_in;
   logic signed [SMP_W-1:0] result_ff, result_in;
   logic signed [EFF_W-1:0] eff_ff, eff_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [EFF_W-1:0] high;
   logic signed [OPA_W-1:0] opa;
   logic [WGT_W-1:0]        opb;
   logic signed [ACC_W-1:0] prod;
   logic signed [QUO_W-1:0] quo;

   assign high = EFF_W'(sample_ff) - EFF_W'(low_ff);
   assign prod = opa * $signed({1'b0, opb});
   assign quo  = div256(acc_ff);

   always_comb begin
      opa = '0;
      opb = '0;
      unique case (ctl.step)
         STEP_LOW_A: begin
            opa = OPA_W'(pin_ff);
            opb = centre;
         end
         STEP_LOW_B: begin
            opa = OPA_W'(plow_ff);
            opb = WEIGHT_ONE - centre;
         end
         STEP_EFF_A: begin
            opa = OPA_W'(high);
            opb = tone;
         end
         STEP_EFF_B: begin
            opa = OPA_W'(low_ff);
            opb = WEIGHT_ONE - tone;
         end
         STEP_OUT_A: begin
            opa = OPA_W'(sample_ff);
            opb = WEIGHT_ONE - wet;
         end
         STEP_OUT_B: begin
            opa = OPA_W'(eff_ff);
            opb = wet;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      sample_in = ctl.load ? sample : sample_ff;
      pin_in    = pin_ff;
      plow_in   = plow_ff;
      low_in    = low_ff;
      eff_in    = eff_ff;
      result_in = result_ff;
      acc_in    = acc_ff;
      unique case (ctl.step) inside
         STEP_LOW_A, STEP_EFF_A, STEP_OUT_A: acc_in = prod;
         STEP_LOW_B, STEP_EFF_B, STEP_OUT_B: acc_in = acc_ff + prod;
         STEP_LOW_DIV: begin
            low_in  = quo[SMP_W-1:0];
            plow_in = quo[SMP_W-1:0];
            pin_in  = sample_ff;
         end
         STEP_EFF_DIV: eff_in = quo[EFF_W-1:0];
         STEP_OUT_DIV: begin
            if (quo > SAT_HI) begin
               result_in = SAT_HI[SMP_W-1:0];
            end else if (quo < SAT_LO) begin
               result_in = SAT_LO[SMP_W-1:0];
            end else begin
               result_in = quo[SMP_W-1:0];
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff  <= '0;
         plow_ff <= '0;
      end else begin
         pin_ff  <= pin_in;
         plow_ff <= plow_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      low_ff    <= low_in;
      eff_ff    <= eff_in;
      result_ff <= result_in;
      acc_ff    <= acc_in;
   end

   assign result = result_ff;

endmodule

// ===== rtl/core/teq_ctrl.sv =====
// Step sequencer shared by both lanes; hands finished frames to the
// output register. Depends on teq_pkg.
module teq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 out_free,
   output logic                 req_ready,
   output logic                 out_load,
   output teq_pkg::teq_ctl_type ctl
);
   import teq_pkg::*;

   teq_step_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STEP_IDLE:    if (req_valid) state_in = STEP_LOW_A;
         STEP_LOW_A:   state_in = STEP_LOW_B;
         STEP_LOW_B:   state_in = STEP_LOW_DIV;
         STEP_LOW_DIV: state_in = STEP_EFF_A;
         STEP_EFF_A:   state_in = STEP_EFF_B;
         STEP_EFF_B:   state_in = STEP_EFF_DIV;
         STEP_EFF_DIV: state_in = STEP_OUT_A;
         STEP_OUT_A:   state_in = STEP_OUT_B;
         STEP_OUT_B:   state_in = STEP_OUT_DIV;
         STEP_OUT_DIV: state_in = STEP_HOLD;
         STEP_HOLD:    if (out_free) state_in = STEP_IDLE;
         default:      state_in = STEP_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         STEP_IDLE: req_ready = 1'b1;
         STEP_HOLD: out_load  = out_free;
         default: begin
            req_ready = 1'b0;
            out_load  = 1'b0;
         end
      endcase
      ctl.load = req_ready && req_valid;
      ctl.step = state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STEP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_reaches_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##10 (state_ff == STEP_HOLD))
      else $error("frame did not reach hold after ten steps");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != STEP_IDLE) |-> !req_ready)
      else $error("request taken while lanes busy");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (out_free && state_ff == STEP_HOLD))
      else $error("output loaded while occupied");

endmodule
